### rtl/lcsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcsh_pkg;

  // fixed payload widths of the channels
  localparam int IN_SYM_W   = 7;
  localparam int OUT_W      = 15;
  localparam int SYM_TAB_N  = 1 << IN_SYM_W;

  // depth of the queue between front and back
  localparam int FIFO_DEPTH = 2;

  // operation codes on the input channel
  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  // what the back end has to do with a queued item
  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_MATCH,
    KIND_DROP
  } kind_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYM,
    ST_TAIL,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

### rtl/lcsh_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcsh_in_if import lcsh_pkg::*;;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [IN_SYM_W-1:0] symbol;
  logic                last;

  modport source (output valid, operation, symbol, last, input ready);
  modport sink   (input valid, operation, symbol, last, output ready);
endinterface

`default_nettype wire

### rtl/lcsh_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcsh_out_if import lcsh_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] lcs_length;
  logic [OUT_W-1:0] removed_from_first;
  logic [OUT_W-1:0] removed_from_second;
  logic             overflow;

  modport source (output valid, lcs_length, removed_from_first, removed_from_second,
                  overflow, input ready);
  modport sink   (input valid, lcs_length, removed_from_first, removed_from_second,
                  overflow, output ready);
endinterface

`default_nettype wire

### rtl/lcsh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcsh_front import lcsh_pkg::*; #(
  parameter int  MAX_LEN = 16384,
  parameter int  SYMBOLS = 128,
  parameter type entry_t = logic
) (
  input  wire         clk,
  input  wire         rst_n,
  lcsh_in_if.sink     in_chan,
  output logic        push_valid,
  input  wire         push_ready,
  output entry_t      push_data
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [IN_SYM_W-1:0] sym_tab [SYM_TAB_N];
  logic [CNT_W-1:0]    first_cnt_r, first_cnt_nxt;
  logic [CNT_W-1:0]    second_cnt_r, second_cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    first_upd, second_upd;
  logic                ovf_upd;
  kind_t               kind;
  logic                accept;

  // symbol folding table, constant per build
  for (genvar g = 0; g < SYM_TAB_N; g++) begin : g_sym_tab
    assign sym_tab[g] = IN_SYM_W'(g % SYMBOLS);
  end

  assign accept        = in_chan.valid && push_ready;
  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid;

  // classify the item and track sequence lengths
  always_comb begin
    first_upd  = first_cnt_r;
    second_upd = second_cnt_r;
    ovf_upd    = ovf_r;
    kind       = KIND_DROP;
    if (in_chan.operation == OP_FIRST) begin
      if (first_cnt_r < CNT_W'(MAX_LEN)) begin
        kind      = KIND_APPEND;
        first_upd = first_cnt_r + CNT_W'(1);
      end else begin
        ovf_upd = 1'b1;
      end
    end else begin
      if (second_cnt_r < CNT_W'(MAX_LEN)) begin
        kind       = KIND_MATCH;
        second_upd = second_cnt_r + CNT_W'(1);
      end else begin
        ovf_upd = 1'b1;
      end
    end

    push_data.kind       = kind;
    push_data.symbol     = sym_tab[in_chan.symbol];
    push_data.last       = in_chan.last;
    push_data.ovf        = ovf_upd;
    push_data.first_cnt  = first_upd;
    push_data.second_cnt = second_upd;

    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    ovf_nxt        = ovf_r;
    if (accept) begin
      if (in_chan.last) begin
        first_cnt_nxt  = '0;
        second_cnt_nxt = '0;
        ovf_nxt        = 1'b0;
      end else begin
        first_cnt_nxt  = first_upd;
        second_cnt_nxt = second_upd;
        ovf_nxt        = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
    end else begin
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/lcsh_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lcsh_fifo import lcsh_pkg::*; #(
  parameter type entry_t = logic
) (
  input  wire    clk,
  input  wire    rst_n,
  input  wire    push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  wire    pop_ready,
  output entry_t pop_data
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  entry_t           entries_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(FIFO_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/lcsh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lcsh_back import lcsh_pkg::*; #(
  parameter int  MAX_LEN = 16384,
  parameter type entry_t = logic
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         pop_valid,
  output logic        pop_ready,
  input  entry_t      pop_data,
  lcsh_out_if.source  out_chan
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = $clog2(MAX_LEN);

  // first sequence symbols and chain tails (tail of chain n stored at n-1)
  logic [IN_SYM_W-1:0] sym_mem  [MAX_LEN];
  logic [POS_W-1:0]    tail_mem [MAX_LEN + 1];

  back_state_t         state_r, state_nxt;
  entry_t              cur_r, cur_nxt;
  logic [POS_W-1:0]    p_r, p_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    chain_r, chain_nxt;
  logic [POS_W-1:0]    disp_r, disp_nxt;
  logic                disp_vld_r, disp_vld_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    lcs_r, rem_first_r, rem_second_r;
  logic                ovf_out_r;
  logic                out_load;
  logic [CNT_W-1:0]    rem_first, rem_second;

  logic                sym_we, sym_re;
  logic [POS_W-1:0]    sym_waddr, sym_raddr;
  logic [IN_SYM_W-1:0] sym_wdata, sym_q;
  logic                tail_we, tail_re;
  logic [CNT_W-1:0]    tail_waddr, tail_raddr;
  logic [POS_W-1:0]    tail_wdata, tail_q;

  logic [CNT_W-1:0]    p_inc;
  logic                scan_end;
  logic                hit;
  logic [CNT_W-1:0]    idx_inc;
  back_state_t         end_state;

  assign pop_ready = state_r == ST_IDLE;
  assign p_inc     = CNT_W'(p_r) + CNT_W'(1);
  assign scan_end  = p_inc == cur_r.first_cnt;
  assign hit       = (sym_q == cur_r.symbol) && (!disp_vld_r || p_r > disp_r);
  assign idx_inc   = idx_r + CNT_W'(1);
  assign end_state = cur_r.last ? ST_DONE : ST_IDLE;

  assign rem_first  = (cur_r.first_cnt >= chain_r) ? cur_r.first_cnt - chain_r : '0;
  assign rem_second = (cur_r.second_cnt >= chain_r) ? cur_r.second_cnt - chain_r : '0;

  // sequencer: append, scan positions, walk chain tails, emit result
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    p_nxt        = p_r;
    idx_nxt      = idx_r;
    chain_nxt    = chain_r;
    disp_nxt     = disp_r;
    disp_vld_nxt = disp_vld_r;
    out_load     = 1'b0;
    sym_we       = 1'b0;
    sym_waddr    = '0;
    sym_wdata    = pop_data.symbol;
    sym_re       = 1'b0;
    sym_raddr    = '0;
    tail_we      = 1'b0;
    tail_waddr   = idx_r;
    tail_wdata   = p_r;
    tail_re      = 1'b0;
    tail_raddr   = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          cur_nxt      = pop_data;
          p_nxt        = '0;
          idx_nxt      = '0;
          disp_vld_nxt = 1'b0;
          state_nxt    = pop_data.last ? ST_DONE : ST_IDLE;
          unique case (pop_data.kind)
            KIND_APPEND: begin
              sym_we    = 1'b1;
              sym_waddr = POS_W'(pop_data.first_cnt - CNT_W'(1));
            end
            KIND_MATCH: begin
              if (pop_data.first_cnt != '0) begin
                sym_re    = 1'b1;
                sym_raddr = '0;
                state_nxt = ST_SYM;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SYM: begin
        if (hit) begin
          if (idx_r >= chain_r) begin
            // opens a new chain: the scan ends here
            tail_we   = 1'b1;
            chain_nxt = chain_r + CNT_W'(1);
            state_nxt = end_state;
          end else begin
            tail_re   = 1'b1;
            state_nxt = ST_TAIL;
          end
        end else if (scan_end) begin
          state_nxt = end_state;
        end else begin
          sym_re    = 1'b1;
          sym_raddr = POS_W'(p_inc);
          p_nxt     = POS_W'(p_inc);
        end
      end

      ST_TAIL: begin
        if (p_r > tail_q) begin
          if (idx_inc >= chain_r) begin
            tail_we    = 1'b1;
            tail_waddr = idx_inc;
            chain_nxt  = chain_r + CNT_W'(1);
            state_nxt  = end_state;
          end else begin
            tail_re    = 1'b1;
            tail_raddr = idx_inc;
            idx_nxt    = idx_inc;
          end
        end else begin
          // lower this tail and move on to the next position
          tail_we      = 1'b1;
          disp_nxt     = tail_q;
          disp_vld_nxt = 1'b1;
          if (scan_end) begin
            state_nxt = end_state;
          end else begin
            sym_re    = 1'b1;
            sym_raddr = POS_W'(p_inc);
            p_nxt     = POS_W'(p_inc);
            state_nxt = ST_SYM;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          chain_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= '0;
      disp_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      disp_vld_r  <= disp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    p_r    <= p_nxt;
    idx_r  <= idx_nxt;
    disp_r <= disp_nxt;
    if (out_load) begin
      lcs_r        <= OUT_W'(chain_r);
      rem_first_r  <= OUT_W'(rem_first);
      rem_second_r <= OUT_W'(rem_second);
      ovf_out_r    <= cur_r.ovf;
    end
  end

  // symbol store
  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    if (sym_re) begin
      sym_q <= sym_mem[sym_raddr];
    end
  end

  // chain tail store
  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[tail_waddr] <= tail_wdata;
    end
    if (tail_re) begin
      tail_q <= tail_mem[tail_raddr];
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.lcs_length          = lcs_r;
  assign out_chan.removed_from_first  = rem_first_r;
  assign out_chan.removed_from_second = rem_second_r;
  assign out_chan.overflow            = ovf_out_r;

endmodule

`default_nettype wire

### rtl/lcs_length_hunt_szymanski_unit.sv
// LCS length unit, Hunt-Szymanski scan.
// in_chan (valid/ready) carries operation, symbol and last. operation 0
// appends the symbol to the first sequence, 1 appends it to the second one
// and runs the match scan. An item with last set produces one result on
// out_chan: lcs_length and, per sequence, its length minus lcs_length, plus
// an overflow flag for items dropped beyond MAX_LEN; all counts then clear.
// A front stage classifies items and keeps the sequence counts, a 2-entry
// queue decouples it from the back-end sequencer that owns both stores.
// Back end work per item: a first-sequence item is written on its pop; a
// second-sequence item also scans first-sequence positions one at a time
// and reads one chain tail at a time, set by the single read port of the
// symbol store and of the tail store; an item marked last adds a done step to
// load the result. A result passes through the queue, the sequencer and the
// output register.
// Reset (rst_n low, synchronous) empties the queue and clears counts and the
// LCS length; the stores need no clearing, so items are taken at once.
// If out_chan stalls, the result is held in the output register; the back
// end keeps working until it reaches the next result, and the front keeps
// accepting until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module lcs_length_hunt_szymanski_unit import lcsh_pkg::*; #(
  parameter int MAX_LEN = 16384,
  parameter int SYMBOLS = 128
) (
  input  wire        clk,
  input  wire        rst_n,
  lcsh_in_if.sink    in_chan,
  lcsh_out_if.source out_chan
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  typedef struct packed {
    kind_t               kind;
    logic [IN_SYM_W-1:0] symbol;
    logic                last;
    logic                ovf;
    logic [CNT_W-1:0]    first_cnt;
    logic [CNT_W-1:0]    second_cnt;
  } entry_t;

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   pop_valid, pop_ready;
  entry_t pop_data;

  // classify and count
  lcsh_front #(
    .MAX_LEN (MAX_LEN),
    .SYMBOLS (SYMBOLS),
    .entry_t (entry_t)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  lcsh_fifo #(
    .entry_t (entry_t)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // stores, scan and result
  lcsh_back #(
    .MAX_LEN (MAX_LEN),
    .entry_t (entry_t)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

### rtl/lcsh_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lcsh_checker import lcsh_pkg::*; (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_ready,
  input wire             in_last,
  input wire             out_valid,
  input wire             out_ready,
  input wire [OUT_W-1:0] out_lcs_length,
  input wire [OUT_W-1:0] out_removed_from_first,
  input wire [OUT_W-1:0] out_removed_from_second,
  input wire             out_overflow
);

  logic [3:0] pending_r, pending_nxt;
  logic       last_in, res_out;

  assign last_in = in_valid && in_ready && in_last;
  assign res_out = out_valid && out_ready;

  // results owed: last items taken minus results delivered
  always_comb begin
    pending_nxt = pending_r;
    if (last_in && !res_out) begin
      pending_nxt = pending_r + 4'd1;
    end else if (res_out && !last_in) begin
      pending_nxt = pending_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // reset leaves no result on the output
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a result only ever answers a last item
  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result without a pending last item");

  // stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its value
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_lcs_length) && $stable(out_removed_from_first)
      && $stable(out_removed_from_second) && $stable(out_overflow))
    else $error("result changed while stalled");

endmodule

bind lcs_length_hunt_szymanski_unit lcsh_checker u_lcsh_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_chan.valid),
  .in_ready                (in_chan.ready),
  .in_last                 (in_chan.last),
  .out_valid               (out_chan.valid),
  .out_ready               (out_chan.ready),
  .out_lcs_length          (out_chan.lcs_length),
  .out_removed_from_first  (out_chan.removed_from_first),
  .out_removed_from_second (out_chan.removed_from_second),
  .out_overflow            (out_chan.overflow)
);

`default_nettype wire
